@@ rtl/idtep_pkg.sv @@
// shared types, constants and helper functions for the date-time to epoch parser
package idtep_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic        parse_error;
  } out_beat_t;

  typedef enum logic [2:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4,
    FLD_SECOND = 3'd5
  } field_t;

  typedef struct packed {
    logic [16:0] year;
    logic [9:0]  month;
    logic [9:0]  day;
    logic [9:0]  hour;
    logic [9:0]  minute;
    logic [16:0] acc;
    field_t      field;
    logic        short_text;
  } snap_t;

  localparam logic [7:0]  CH_DASH  = 8'h2D;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_T     = 8'h54;
  localparam logic [7:0]  CH_Z     = 8'h5A;
  localparam logic [7:0]  CH_0     = 8'h30;
  localparam logic [7:0]  CH_9     = 8'h39;

  localparam int          SECONDS_MIN_LEN = 17;
  localparam logic [16:0] ACC_MAX         = 17'd99999;
  localparam logic [9:0]  SHORT_MAX       = 10'd1023;
  localparam logic [16:0] YEAR_MIN        = 17'd1900;
  localparam logic [16:0] YEAR_MAX        = 17'd2100;
  localparam logic [9:0]  MONTH_MAX       = 10'd12;
  localparam logic [9:0]  DAY_MAX         = 10'd31;
  localparam logic [9:0]  HOUR_MAX        = 10'd23;
  localparam logic [9:0]  MINSEC_MAX      = 10'd59;

  function automatic logic [9:0] clip10(input logic [16:0] v);
    clip10 = (v > 17'(SHORT_MAX)) ? SHORT_MAX : v[9:0];
  endfunction

  function automatic logic [7:0] sep_char(input field_t f);
    case (f)
      FLD_YEAR, FLD_MONTH:  sep_char = CH_DASH;
      FLD_DAY:              sep_char = CH_T;
      FLD_HOUR, FLD_MINUTE: sep_char = CH_COLON;
      default:              sep_char = CH_DASH;
    endcase
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd1:    cum_days = 9'd0;
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

endpackage

@@ rtl/idtep_field_parser.sv @@
// input register, per-character field state and end-of-text snapshot register
module idtep_field_parser #(
  parameter int MAX_CHARS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  idtep_pkg::in_beat_t in_data,
  output logic              snap_valid,
  output idtep_pkg::snap_t  snap,
  input  logic              snap_take
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  logic                v0_r, v0_nxt;
  idtep_pkg::in_beat_t in_r;

  idtep_pkg::field_t field_r, field_nxt, field_upd;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_upd;
  logic              run_over_r, run_over_nxt, run_over_upd;
  logic [16:0]       acc_r, acc_nxt, acc_upd;
  logic [16:0]       year_r, year_nxt, year_upd;
  logic [9:0]        month_r, month_nxt, month_upd;
  logic [9:0]        day_r, day_nxt, day_upd;
  logic [9:0]        hour_r, hour_nxt, hour_upd;
  logic [9:0]        minute_r, minute_nxt, minute_upd;
  logic              zulu_r, zulu_nxt, zulu_upd;

  logic              v1_r, v1_nxt;
  idtep_pkg::snap_t  snap_r, snap_nxt;

  logic        s0_go, s1_free, in_acc;
  logic        take, is_sep, is_digit;
  logic [20:0] acc_mul;

  assign s1_free  = !v1_r || snap_take;
  assign s0_go    = v0_r && (!in_r.last || s1_free);
  assign in_stall = v0_r && !s0_go;
  assign in_acc   = in_valid && !in_stall;

  assign take     = !zulu_r && (cnt_r < CNT_W'(MAX_CHARS));
  assign is_sep   = (field_r < idtep_pkg::FLD_SECOND) &&
                    (in_r.ch == idtep_pkg::sep_char(field_r));
  assign is_digit = (in_r.ch >= idtep_pkg::CH_0) && (in_r.ch <= idtep_pkg::CH_9);
  assign acc_mul  = 21'({acc_r, 3'b000}) + 21'({acc_r, 1'b0}) + {17'd0, in_r.ch[3:0]};

  always_comb begin
    field_upd    = field_r;
    cnt_upd      = cnt_r;
    run_over_upd = run_over_r;
    acc_upd      = acc_r;
    year_upd     = year_r;
    month_upd    = month_r;
    day_upd      = day_r;
    hour_upd     = hour_r;
    minute_upd   = minute_r;
    zulu_upd     = zulu_r;
    if (take) begin
      if (in_r.ch == idtep_pkg::CH_Z) begin
        zulu_upd = 1'b1;
      end else begin
        cnt_upd = cnt_r + 1'b1;
        if (is_sep) begin
          case (field_r)
            idtep_pkg::FLD_YEAR:  year_upd   = acc_r;
            idtep_pkg::FLD_MONTH: month_upd  = idtep_pkg::clip10(acc_r);
            idtep_pkg::FLD_DAY:   day_upd    = idtep_pkg::clip10(acc_r);
            idtep_pkg::FLD_HOUR:  hour_upd   = idtep_pkg::clip10(acc_r);
            default:              minute_upd = idtep_pkg::clip10(acc_r);
          endcase
          field_upd    = idtep_pkg::field_t'(3'(field_r) + 3'd1);
          acc_upd      = 17'd0;
          run_over_upd = 1'b0;
        end else if (is_digit && !run_over_r) begin
          acc_upd = (acc_mul > 21'(idtep_pkg::ACC_MAX)) ? idtep_pkg::ACC_MAX : acc_mul[16:0];
        end else begin
          run_over_upd = 1'b1;
        end
      end
    end
  end

  always_comb begin
    field_nxt    = field_r;
    cnt_nxt      = cnt_r;
    run_over_nxt = run_over_r;
    acc_nxt      = acc_r;
    year_nxt     = year_r;
    month_nxt    = month_r;
    day_nxt      = day_r;
    hour_nxt     = hour_r;
    minute_nxt   = minute_r;
    zulu_nxt     = zulu_r;
    if (s0_go) begin
      if (in_r.last) begin
        field_nxt    = idtep_pkg::FLD_YEAR;
        cnt_nxt      = '0;
        run_over_nxt = 1'b0;
        acc_nxt      = '0;
        year_nxt     = '0;
        month_nxt    = '0;
        day_nxt      = '0;
        hour_nxt     = '0;
        minute_nxt   = '0;
        zulu_nxt     = 1'b0;
      end else begin
        field_nxt    = field_upd;
        cnt_nxt      = cnt_upd;
        run_over_nxt = run_over_upd;
        acc_nxt      = acc_upd;
        year_nxt     = year_upd;
        month_nxt    = month_upd;
        day_nxt      = day_upd;
        hour_nxt     = hour_upd;
        minute_nxt   = minute_upd;
        zulu_nxt     = zulu_upd;
      end
    end
  end

  always_comb begin
    snap_nxt.year       = year_upd;
    snap_nxt.month      = month_upd;
    snap_nxt.day        = day_upd;
    snap_nxt.hour       = hour_upd;
    snap_nxt.minute     = minute_upd;
    snap_nxt.acc        = acc_upd;
    snap_nxt.field      = field_upd;
    snap_nxt.short_text = cnt_upd < CNT_W'(idtep_pkg::SECONDS_MIN_LEN);
  end

  assign v0_nxt = in_acc ? 1'b1 : (s0_go ? 1'b0 : v0_r);
  assign v1_nxt = (s0_go && in_r.last) ? 1'b1 : (snap_take ? 1'b0 : v1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      field_r    <= idtep_pkg::FLD_YEAR;
      cnt_r      <= '0;
      run_over_r <= 1'b0;
      acc_r      <= '0;
      year_r     <= '0;
      month_r    <= '0;
      day_r      <= '0;
      hour_r     <= '0;
      minute_r   <= '0;
      zulu_r     <= 1'b0;
    end else begin
      v0_r       <= v0_nxt;
      v1_r       <= v1_nxt;
      field_r    <= field_nxt;
      cnt_r      <= cnt_nxt;
      run_over_r <= run_over_nxt;
      acc_r      <= acc_nxt;
      year_r     <= year_nxt;
      month_r    <= month_nxt;
      day_r      <= day_nxt;
      hour_r     <= hour_nxt;
      minute_r   <= minute_nxt;
      zulu_r     <= zulu_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (s0_go && in_r.last) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = v1_r;
  assign snap       = snap_r;

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_go && in_r.last) |=> (field_r == idtep_pkg::FLD_YEAR && cnt_r == '0 && !zulu_r))
    else $error("field state not cleared after last beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CHARS))
    else $error("character count past limit");
`endif

endmodule

@@ rtl/idtep_epoch_calc.sv @@
// range check, day and second counts, and epoch result register
module idtep_epoch_calc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 snap_valid,
  input  idtep_pkg::snap_t     snap,
  output logic                 snap_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output idtep_pkg::out_beat_t out_data
);

  logic               v2_r, v2_nxt;
  logic               err_r, err_nxt;
  logic signed [17:0] days_r, days_nxt;
  logic [16:0]        sod_r, sod_nxt;

  logic                 out_valid_r, out_valid_nxt;
  idtep_pkg::out_beat_t out_r, out_nxt;

  logic        s3_free, s2_go, s2_free;
  logic        fmiss, bad;
  logic [9:0]  mn, sc;
  logic [7:0]  y8;
  logic        leap;
  logic [8:0]  yday;
  logic signed [8:0]  ya, adj, yoff;
  logic signed [31:0] days32, prod;

  assign s3_free   = !out_valid_r || !out_stall;
  assign s2_go     = v2_r && s3_free;
  assign s2_free   = !v2_r || s2_go;
  assign snap_take = snap_valid && s2_free;

  always_comb begin
    fmiss = (snap.field < idtep_pkg::FLD_MINUTE) ||
            (snap.field == idtep_pkg::FLD_MINUTE && !snap.short_text);
    mn    = (snap.field == idtep_pkg::FLD_MINUTE) ? idtep_pkg::clip10(snap.acc) : snap.minute;
    sc    = (snap.field == idtep_pkg::FLD_SECOND && !snap.short_text) ?
            idtep_pkg::clip10(snap.acc) : 10'd0;
    bad   = (snap.year < idtep_pkg::YEAR_MIN) || (snap.year > idtep_pkg::YEAR_MAX) ||
            (snap.month == 10'd0) || (snap.month > idtep_pkg::MONTH_MAX) ||
            (snap.day == 10'd0) || (snap.day > idtep_pkg::DAY_MAX) ||
            (snap.hour > idtep_pkg::HOUR_MAX) || (mn > idtep_pkg::MINSEC_MAX) ||
            (sc > idtep_pkg::MINSEC_MAX);
    err_nxt = fmiss || bad;

    // year offset from 1900, valid only when in range
    y8   = 8'(snap.year - idtep_pkg::YEAR_MIN);
    leap = (y8[1:0] == 2'b00) && (y8 != 8'd0) && (y8 != 8'd200);
    yday = idtep_pkg::cum_days(snap.month[3:0]) + 9'(leap && (snap.month > 10'd2)) +
           9'(snap.day[4:0]) - 9'd1;

    // century terms cancel over 1900..2100, leaving the truncated quarter
    ya   = $signed({1'b0, y8}) - 9'sd69;
    adj  = (ya >= 0) ? (ya >>> 2) : -((-ya) >>> 2);
    yoff = $signed({1'b0, y8}) - 9'sd70;
    days_nxt = 18'(yoff * 18'sd365) + 18'(adj) + $signed({9'd0, yday});
    sod_nxt  = 17'(snap.hour[4:0] * 17'd3600) + 17'(mn[5:0] * 17'd60) + 17'(sc[5:0]);
  end

  always_comb begin
    days32 = 32'(days_r);
    prod   = days32 * 32'sd86400;
    out_nxt.parse_error   = err_r;
    out_nxt.epoch_seconds = err_r ? 32'd0 : (32'(prod) + {15'd0, sod_r});
  end

  assign v2_nxt        = snap_take ? 1'b1 : (s2_go ? 1'b0 : v2_r);
  assign out_valid_nxt = s2_go ? 1'b1 : (s3_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      err_r  <= err_nxt;
      days_r <= days_nxt;
      sod_r  <= sod_nxt;
    end
    if (s2_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.parse_error) |-> (out_r.epoch_seconds == 32'd0))
    else $error("error result carries nonzero epoch");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !s3_free) |=> (v2_r && $stable(days_r) && $stable(err_r)))
    else $error("calc stage lost while output stalled");
`endif

endmodule

@@ rtl/iso_datetime_to_epoch_parser.sv @@
// top level: ISO date-time text to epoch seconds, one character beat per cycle while in_stall is low
// throughput: one character beat per cycle, back to back, except that in_stall holds off input while a final beat waits
// path of the final beat, in order: input register, field snapshot, day count stage,
// epoch multiply into output register
// reset: synchronous active-low rst_n clears all valid bits and field state
module iso_datetime_to_epoch_parser #(
  parameter int MAX_CHARS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  idtep_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output idtep_pkg::out_beat_t out_data
);

  logic             snap_valid;
  logic             snap_take;
  idtep_pkg::snap_t snap;

  idtep_field_parser #(
    .MAX_CHARS(MAX_CHARS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .snap_valid(snap_valid),
    .snap      (snap),
    .snap_take (snap_take)
  );

  idtep_epoch_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_valid(snap_valid),
    .snap      (snap),
    .snap_take (snap_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the date-time to epoch parser: streams texts, predicts every epoch
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_MAX = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CHAR_TARGET = 1400;
  localparam int DAYS_PER_MONTH[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef logic [7:0] text_t[$];

  class epoch_board;
    idtep_pkg::out_beat_t expected_epochs[$];
    int mismatches;
    idtep_pkg::field_t fld;
    int nchars;
    bit run_over;
    bit zulu;
    logic [16:0] acc;
    logic [16:0] yr;
    logic [9:0] mon;
    logic [9:0] dd;
    logic [9:0] hh;
    logic [9:0] mi;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      fld = idtep_pkg::FLD_YEAR;
      nchars = 0;
      run_over = 1'b0;
      zulu = 1'b0;
      acc = '0;
      yr = '0;
      mon = '0;
      dd = '0;
      hh = '0;
      mi = '0;
    endfunction

    function logic [9:0] sat10(logic [16:0] v);
      return (v > 17'(idtep_pkg::SHORT_MAX)) ? idtep_pkg::SHORT_MAX : v[9:0];
    endfunction

    function logic [7:0] sep_of(idtep_pkg::field_t f);
      case (f)
        idtep_pkg::FLD_YEAR, idtep_pkg::FLD_MONTH: return idtep_pkg::CH_DASH;
        idtep_pkg::FLD_DAY:                        return idtep_pkg::CH_T;
        default:                                   return idtep_pkg::CH_COLON;
      endcase
    endfunction

    function void take_char(logic [7:0] c);
      int v;
      if (c == idtep_pkg::CH_Z) begin
        zulu = 1'b1;
        return;
      end
      nchars++;
      if (fld != idtep_pkg::FLD_SECOND && c == sep_of(fld)) begin
        case (fld)
          idtep_pkg::FLD_YEAR:  yr = acc;
          idtep_pkg::FLD_MONTH: mon = sat10(acc);
          idtep_pkg::FLD_DAY:   dd = sat10(acc);
          idtep_pkg::FLD_HOUR:  hh = sat10(acc);
          default:              mi = sat10(acc);
        endcase
        fld = idtep_pkg::field_t'(fld + 1);
        acc = '0;
        run_over = 1'b0;
      end else if (c >= idtep_pkg::CH_0 && c <= idtep_pkg::CH_9 && !run_over) begin
        v = acc * 10 + (c - idtep_pkg::CH_0);
        acc = (v > idtep_pkg::ACC_MAX) ? idtep_pkg::ACC_MAX : v[16:0];
      end else begin
        run_over = 1'b1;
      end
    endfunction

    function idtep_pkg::out_beat_t finish_text();
      idtep_pkg::out_beat_t r;
      logic [9:0] mn;
      logic [9:0] sc;
      bit shrt;
      bit leap;
      int yday;
      longint ly;
      longint t;
      r.epoch_seconds = '0;
      r.parse_error = 1'b1;
      mn = '0;
      sc = '0;
      shrt = nchars < idtep_pkg::SECONDS_MIN_LEN;
      if (fld < idtep_pkg::FLD_MINUTE) return r;
      if (fld == idtep_pkg::FLD_MINUTE) begin
        if (!shrt) return r;
        mn = sat10(acc);
      end else begin
        mn = mi;
        sc = shrt ? 10'd0 : sat10(acc);
      end
      if (yr < idtep_pkg::YEAR_MIN || yr > idtep_pkg::YEAR_MAX || mon < 1 ||
          mon > idtep_pkg::MONTH_MAX || dd < 1 || dd > idtep_pkg::DAY_MAX ||
          hh > idtep_pkg::HOUR_MAX || mn > idtep_pkg::MINSEC_MAX ||
          sc > idtep_pkg::MINSEC_MAX)
        return r;
      leap = (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
      yday = dd - 1;
      for (int m = 0; m + 1 < mon; m++) begin
        yday += DAYS_PER_MONTH[m];
        if (m == 1 && leap) yday++;
      end
      ly = longint'(yr) - 1900;
      t = longint'(sc) + longint'(mn) * 60 + longint'(hh) * 3600 + longint'(yday) * 86400 +
          (ly - 70) * 31536000 + ((ly - 69) / 4) * 86400 - ((ly - 1) / 100) * 86400 +
          ((ly + 299) / 400) * 86400;
      r.epoch_seconds = t[31:0];
      r.parse_error = 1'b0;
      return r;
    endfunction

    function void note_char(idtep_pkg::in_beat_t b);
      if (!zulu && nchars < TEXT_MAX) take_char(b.ch);
      if (b.last) begin
        expected_epochs.push_back(finish_text());
        clear();
      end
    endfunction

    function void check_epoch(idtep_pkg::out_beat_t got);
      idtep_pkg::out_beat_t want;
      if (expected_epochs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: epoch %0d err %0b", got.epoch_seconds, got.parse_error);
        return;
      end
      want = expected_epochs.pop_front();
      if (got.epoch_seconds !== want.epoch_seconds || got.parse_error !== want.parse_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected epoch %0d err %0b, got epoch %0d err %0b",
                   want.epoch_seconds, want.parse_error, got.epoch_seconds, got.parse_error);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  idtep_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  idtep_pkg::out_beat_t out_data;

  epoch_board board = new();
  bit calm;

  iso_datetime_to_epoch_parser #(.MAX_CHARS(TEXT_MAX)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 5))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return idtep_pkg::CH_0 + 8'($urandom_range(0, 9));
      3:       return idtep_pkg::CH_DASH;
      4:       return idtep_pkg::CH_COLON;
      default: return $urandom_range(0, 1) ? idtep_pkg::CH_T : idtep_pkg::CH_Z;
    endcase
  endfunction

  function automatic text_t str2text(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic void put_num(ref text_t t, input int v, input int w);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < w) s = {"0", s};
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  function automatic int pick_val(int lo, int hi, bit good);
    if (good || $urandom_range(0, 1)) return $urandom_range(lo, hi);
    case ($urandom_range(0, 3))
      0:       return (lo > 0) ? lo - 1 : hi + 1;
      1:       return hi + 1;
      2:       return $urandom_range(0, 9999);
      default: return $urandom_range(0, 9999999);
    endcase
  endfunction

  function automatic text_t random_text();
    text_t t;
    int lo_v[6] = '{1900, 1, 1, 0, 0, 0};
    int hi_v[6] = '{2100, 12, 31, 23, 59, 59};
    int wd[6] = '{4, 2, 2, 2, 2, 2};
    logic [7:0] seps[5] = '{idtep_pkg::CH_DASH, idtep_pkg::CH_DASH, idtep_pkg::CH_T,
                            idtep_pkg::CH_COLON, idtep_pkg::CH_COLON};
    int kind;
    int nf;
    int pos;
    bit good;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 40)) t.push_back(8'($urandom_range(0, 255)));
      return t;
    end
    good = kind < 65;
    nf = good ? $urandom_range(5, 6) : $urandom_range(1, 6);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) t.push_back((good || $urandom_range(0, 9) != 0) ? seps[f - 1] : rand_char());
      put_num(t, pick_val(lo_v[f], hi_v[f], good), good ? wd[f] : $urandom_range(0, 6));
    end
    if ($urandom_range(0, 2) == 0) t.push_back(idtep_pkg::CH_Z);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 8)) t.push_back(rand_char());
    if (!good) begin
      repeat ($urandom_range(0, 2)) begin
        pos = $urandom_range(0, t.size() - 1);
        case ($urandom_range(0, 2))
          0: t[pos] = rand_char();
          1: if (t.size() > 1) t.delete(pos);
          default: t.insert(pos, rand_char());
        endcase
      end
    end
    return t;
  endfunction

  task automatic send_char(logic [7:0] c, logic l);
    idtep_pkg::in_beat_t b;
    int gap;
    b.ch = c;
    b.last = l;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    board.note_char(b);
  endtask

  task automatic send_text(text_t t);
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_epochs.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_epoch(out_data);
  end

  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < 20) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    string directed[$] = '{
      "1970-01-01T00:00:00Z", "2100-12-31T23:59:59Z", "1900-01-01T00:00:00",
      "2000-02-29T12:34", "2024-03-01T01:02:3", "2020-1-5T7:8:9",
      "1899-12-31T23:59:59", "2101-01-01T00:00:00", "2001-13-00T00:00:00",
      "2001-02-30T24:60:60", "2001-01-01T00-00", "2001-01-01T10:20xx55",
      "12345678-01-01T00:00", "2038-01-19T03:14:08Z+junk", " 1970-01-01T00:00:00",
      "+1970-01-01T00:00:00", "1970-01-01T00:00:00.000Z99", "Z", "2016-12-31T23:59:60Z"};
    text_t t;
    int sent;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_text(str2text(directed[i]));
    t = '{8'h00, 8'hFF, 8'h80, 8'h7F, idtep_pkg::CH_Z};
    send_text(t);
    drain_results();
    sent = 0;
    while (sent < CHAR_TARGET) begin
      t = random_text();
      calm = ($urandom_range(0, 4) == 0);
      send_text(t);
      sent += t.size();
      if ($urandom_range(0, 39) == 0) drain_results();
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.expected_epochs.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
